[src/qjrm_pkg.sv]
package qjrm_pkg;

  // fixed-point format and loop bounds
  localparam int FRAC_BITS         = 28;
  localparam int ESCAPE_ITERATIONS = 10;
  localparam int MARCH_STEPS       = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam int STEP_W    = $clog2(MARCH_STEPS + 1);
  localparam int IT_W      = $clog2(ESCAPE_ITERATIONS + 1);
  localparam int LNC_W     = $clog2(FRAC_BITS + 1);
  localparam int DIV_W     = 96;
  localparam int DC_W      = $clog2(DIV_W);
  localparam int CFG_IDX_W = 3;

  // saturation limits and thresholds
  localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] ONE_F     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] QLIM      = (64'sd1 <<< (FRAC_BITS + 8)) - 64'sd1;
  localparam logic signed [63:0] DLIM      = (64'sd1 <<< 61) - 64'sd1;
  localparam logic signed [63:0] POS_LIM   = INT64_MAX >>> 2;
  localparam logic signed [63:0] DCAP      = 64'sd16 <<< FRAC_BITS;
  localparam logic signed [63:0] ESC_LIMIT = 64'sd10 <<< FRAC_BITS;
  localparam logic signed [63:0] MAX_DIST  = 64'sd10 <<< FRAC_BITS;
  localparam logic signed [63:0] LN2_Q32   = 64'sd2977044472;

  // register reset values
  localparam logic signed [31:0] RST_C_W   = -32'sd53687091;
  localparam logic signed [31:0] RST_C_X   = 32'sd161061274;
  localparam logic signed [31:0] RST_C_Y   = 32'sd53687091;
  localparam logic signed [31:0] RST_C_Z   = 32'sd53687091;
  localparam logic signed [31:0] RST_EYE_X = 32'sd0;
  localparam logic signed [31:0] RST_EYE_Y = 32'sd0;
  localparam logic signed [31:0] RST_EYE_Z = 32'sd563714458;
  localparam logic [30:0]        RST_HIT_D = 31'd268435;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_W, REG_C_X, REG_C_Y, REG_C_Z,
    REG_EYE_X, REG_EYE_Y, REG_EYE_Z, REG_HIT_DISTANCE
  } cfg_reg_t;

  // multiplier operation: picks the result shift and saturation limit
  typedef enum logic [2:0] {
    MUL_POS, MUL_DQ, MUL_Q, MUL_QD, MUL_SQ, MUL_LN, MUL_NUM, MUL_RAW
  } mul_op_t;

  typedef struct packed {
    logic signed [31:0] c_w;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic [30:0]        hit_distance;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  // magnitude of a signed word as unsigned
  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                input logic signed [63:0] lim);
    if (v > lim) sat64 = lim;
    else if (v < -lim) sat64 = -lim;
    else sat64 = v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) sat32 = 32'sh7fff_ffff;
    else if (v < -64'sh0000_0000_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  // quaternion product sign: term j of component i enters negated
  function automatic logic qneg(input logic [1:0] i, input logic [1:0] j);
    qneg = ((i == 2'd0) && (j != 2'd0)) || ((i == 2'd1) && (j == 2'd3)) ||
           ((i == 2'd2) && (j == 2'd1)) || ((i == 2'd3) && (j == 2'd2));
  endfunction

endpackage

[src/qjrm_if.sv]
interface qjrm_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface qjrm_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, hit, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, hit, pos_x, pos_y, pos_z, output ready);
endinterface

[src/qjrm_front.sv]
module qjrm_front (
  input  logic           clk,
  input  logic           rst,
  qjrm_ray_if.sink       ray,
  input  logic           pop,
  output qjrm_pkg::ray_t head,
  output logic           head_valid
);
  import qjrm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ray_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] cnt;
  logic             push;

  // queue status
  assign ray.ready  = (cnt != CNT_W'(QUEUE_DEPTH));
  assign push       = ray.valid && ray.ready;
  assign head       = slots[rp];
  assign head_valid = (cnt != '0);

  // ray queue between intake and marcher
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        slots[wp] <= '{dir_x: ray.dir_x, dir_y: ray.dir_y, dir_z: ray.dir_z};
        wp <= (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

[src/qjrm_mul.sv]
module qjrm_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  qjrm_pkg::mul_op_t  op,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] prod
);
  import qjrm_pkg::*;

  logic          busy;
  logic [2:0]    cnt;
  logic [1:0]    pk;
  logic [63:0]   ma;
  logic [63:0]   mb;
  logic          neg;
  mul_op_t       op_r;
  logic [63:0]   preg;
  logic [127:0]  acc;
  logic [127:0]  addend;
  logic [31:0]   pa;
  logic [31:0]   pb;
  logic [127:0]  shifted;
  logic [63:0]   lim;
  logic [63:0]   capped;

  // partial product select and finishing shift
  always_comb begin
    pa = cnt[1] ? ma[63:32] : ma[31:0];
    pb = cnt[0] ? mb[63:32] : mb[31:0];
    case (pk)
      2'd0:    addend = {64'd0, preg};
      2'd3:    addend = {preg, 64'd0};
      default: addend = {32'd0, preg, 32'd0};
    endcase
    case (op_r)
      MUL_POS: begin shifted = acc >> FRAC_BITS;       lim = POS_LIM;   end
      MUL_DQ:  begin shifted = acc >> (FRAC_BITS - 1); lim = DLIM;      end
      MUL_Q:   begin shifted = acc >> FRAC_BITS;       lim = QLIM;      end
      MUL_QD:  begin shifted = acc >> (FRAC_BITS - 1); lim = QLIM;      end
      MUL_SQ:  begin shifted = acc >> FRAC_BITS;       lim = INT64_MAX; end
      MUL_LN:  begin shifted = acc >> 32;              lim = INT64_MAX; end
      MUL_NUM: begin shifted = acc >> (FRAC_BITS + 2); lim = INT64_MAX; end
      default: begin shifted = acc;                    lim = INT64_MAX; end
    endcase
    capped = (shifted > {64'd0, lim}) ? lim : shifted[63:0];
  end

  // four 32x32 partial products, each registered before accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        ma   <= mag64(a);
        mb   <= mag64(b);
        neg  <= a[63] ^ b[63];
        op_r <= op;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt < 3'd4) begin
          preg <= 64'(pa) * 64'(pb);
          pk   <= cnt[1:0];
        end
        if ((cnt >= 3'd1) && (cnt <= 3'd4)) acc <= acc + addend;
        if (cnt == 3'd5) begin
          prod <= neg ? -$signed(capped) : $signed(capped);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[src/qjrm_isqrt.sv]
module qjrm_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);
  logic        busy;
  logic        aligned;
  logic [63:0] xr;
  logic [63:0] rr;
  logic [63:0] bt;
  logic [63:0] trial;

  assign trial = rr + bt;
  assign root  = rr[31:0];

  // digit-by-digit root, two bits of the radicand per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      aligned <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr      <= x;
        rr      <= '0;
        bt      <= 64'h4000_0000_0000_0000;
        busy    <= 1'b1;
        aligned <= 1'b0;
      end else if (busy) begin
        if (!aligned) begin
          if (bt > xr) bt <= bt >> 2;
          else aligned <= 1'b1;
        end else if (bt == '0) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (xr >= trial) begin
            xr <= xr - trial;
            rr <= (rr >> 1) + bt;
          end else begin
            rr <= rr >> 1;
          end
          bt <= bt >> 2;
        end
      end
    end
  end

endmodule

[src/qjrm_march.sv]
module qjrm_march (
  input  logic           clk,
  input  logic           rst,
  input  qjrm_pkg::cfg_t cfg,
  input  qjrm_pkg::ray_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           busy,
  qjrm_res_if.source     res
);
  import qjrm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_POS, S_ND, S_NQ, S_UPD, S_M2, S_CHK, S_SQS, S_SQRT, S_LNN,
    S_LNS, S_LNM, S_NUM, S_HMAX, S_HSH, S_HSQ, S_HROOT, S_DIV, S_DFIN,
    S_DEC, S_ADV, S_OUT
  } state_t;

  state_t             st;
  logic               pend;
  logic [1:0]         i;
  logic [1:0]         j;
  logic [2:0]         k;
  logic [IT_W-1:0]    it;
  logic [STEP_W-1:0]  step;
  logic signed [31:0] dir [3];
  logic signed [31:0] p [3];
  logic signed [63:0] q [4];
  logic signed [63:0] dq [4];
  logic signed [63:0] nd [4];
  logic signed [63:0] nq [4];
  logic signed [63:0] t;
  logic signed [63:0] acc;
  logic signed [63:0] d;
  logic signed [63:0] lnv;
  logic signed [63:0] num;
  logic signed [63:0] sqv;
  logic [63:0]        m2;
  logic [63:0]        sv;
  logic [63:0]        lx;
  logic [63:0]        mx;
  logic [63:0]        hsum;
  logic [63:0]        den;
  logic [4:0]         ss;
  logic [5:0]         hs;
  logic signed [7:0]  ln_n;
  logic [FRAC_BITS-1:0] lf;
  logic [LNC_W-1:0]   lc;
  logic [DIV_W-1:0]   rq;
  logic [64:0]        rem;
  logic [DC_W-1:0]    dc;
  logic               hitr;
  logic               ov;
  logic               o_hit;
  logic signed [31:0] o_x;
  logic signed [31:0] o_y;
  logic signed [31:0] o_z;

  logic               mul_start;
  logic               mul_done;
  mul_op_t            mul_op;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic signed [63:0] mres;
  logic               sq_start;
  logic               sq_done;
  logic [63:0]        sq_x;
  logic [31:0]        sq_root;

  logic [1:0]         qidx;
  logic [1:0]         didx;
  logic signed [63:0] qa;
  logic signed [63:0] db;
  logic [63:0]        hm;
  logic signed [63:0] eye_i;
  logic signed [63:0] pos_v;
  logic signed [63:0] nd_sum;
  logic signed [63:0] lnarg;
  logic [61:0]        lsq;
  logic [31:0]        lxx;
  logic [63:0]        mg [4];
  logic [63:0]        m01;
  logic [63:0]        m23;
  logic [63:0]        dn;
  logic [64:0]        rs;
  logic               ge;
  logic               esc;

  qjrm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op    (mul_op),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mres)
  );

  qjrm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  // handshakes and status
  assign pop       = (st == S_IDLE) && head_valid;
  assign busy      = (st != S_IDLE);
  assign res.valid = ov;
  assign res.hit   = o_hit;
  assign res.pos_x = o_x;
  assign res.pos_y = o_y;
  assign res.pos_z = o_z;

  // operand selection for the shared units
  always_comb begin
    qidx = i;
    if (st == S_ND) qidx = j;
    else if (st == S_NQ) qidx = (k < 3'd4) ? k[1:0] : 2'(k - 3'd3);
    didx = (st == S_ND) ? (i ^ j) : i;
    qa   = q[qidx];
    db   = dq[didx];
    hm   = mag64(db) >> hs;

    case (i)
      2'd0:    eye_i = 64'($signed(cfg.eye_x));
      2'd1:    eye_i = 64'($signed(cfg.eye_y));
      default: eye_i = 64'($signed(cfg.eye_z));
    endcase
    pos_v  = eye_i + mres;
    nd_sum = acc + (qneg(i, j) ? -mres : mres);
    esc    = m2 > 64'(ESC_LIMIT);

    lnarg = ((64'(ln_n) - 64'(FRAC_BITS)) <<< FRAC_BITS) +
            $signed({{(64 - FRAC_BITS){1'b0}}, lf});
    lsq   = 62'(lx[30:0]) * 62'(lx[30:0]);
    lxx   = lsq[61:30];

    for (int n = 0; n < 4; n++) mg[n] = mag64(dq[n]);
    m01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    m23 = (mg[2] > mg[3]) ? mg[2] : mg[3];

    dn = 64'(sq_root) << hs;
    rs = {rem[63:0], rq[DIV_W-1]};
    ge = rs >= {1'b0, den};

    mul_a     = qa;
    mul_b     = db;
    mul_op    = MUL_DQ;
    mul_start = 1'b0;
    case (st)
      S_POS: begin
        mul_a     = {{32{dir[i][31]}}, dir[i]};
        mul_b     = t;
        mul_op    = MUL_POS;
        mul_start = !pend;
      end
      S_ND: begin
        mul_start = !pend;
      end
      S_NQ: begin
        mul_b     = (k < 3'd4) ? qa : q[0];
        mul_op    = (k < 3'd4) ? MUL_Q : MUL_QD;
        mul_start = !pend;
      end
      S_M2: begin
        mul_b     = qa;
        mul_op    = MUL_SQ;
        mul_start = !pend;
      end
      S_LNM: begin
        mul_a     = lnarg;
        mul_b     = LN2_Q32;
        mul_op    = MUL_LN;
        mul_start = !pend;
      end
      S_NUM: begin
        mul_a     = sqv;
        mul_b     = lnv;
        mul_op    = MUL_NUM;
        mul_start = !pend;
      end
      S_HSQ: begin
        mul_a     = $signed(hm);
        mul_b     = $signed(hm);
        mul_op    = MUL_RAW;
        mul_start = !pend;
      end
      default: ;
    endcase

    sq_start = ((st == S_SQRT) || (st == S_HROOT)) && !pend;
    sq_x     = (st == S_SQRT) ? (sv << FRAC_BITS) : hsum;
  end

  // march sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      pend <= 1'b0;
      ov   <= 1'b0;
    end else begin
      if (ov && res.ready) ov <= 1'b0;
      if (mul_start || sq_start) pend <= 1'b1;
      case (st)
        // take a ray from the queue
        S_IDLE: begin
          if (head_valid) begin
            dir[0] <= head.dir_x;
            dir[1] <= head.dir_y;
            dir[2] <= head.dir_z;
            t      <= ONE_F;
            step   <= '0;
            i      <= '0;
            hitr   <= 1'b0;
            st     <= S_POS;
          end
        end
        // point on the ray
        S_POS: begin
          if (mul_done) begin
            pend <= 1'b0;
            p[i] <= sat32(pos_v);
            if (i == 2'd2) begin
              q[0]  <= 64'(p[0]);
              q[1]  <= 64'(p[1]);
              q[2]  <= 64'(sat32(pos_v));
              q[3]  <= '0;
              dq[0] <= 64'sd1 <<< 32;
              dq[1] <= '0;
              dq[2] <= '0;
              dq[3] <= '0;
              it    <= '0;
              i     <= '0;
              j     <= '0;
              acc   <= '0;
              st    <= S_ND;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        // derivative terms
        S_ND: begin
          if (mul_done) begin
            pend <= 1'b0;
            j    <= j + 1'b1;
            if (j == 2'd3) begin
              nd[i] <= sat64(nd_sum, DLIM);
              acc   <= '0;
              i     <= i + 1'b1;
              if (i == 2'd3) begin
                k  <= '0;
                st <= S_NQ;
              end
            end else begin
              acc <= nd_sum;
            end
          end
        end
        // square of q
        S_NQ: begin
          if (mul_done) begin
            pend <= 1'b0;
            if (k == 3'd0) nq[0] <= mres;
            else if (k < 3'd4) nq[0] <= nq[0] - mres;
            else nq[2'(k - 3'd3)] <= mres;
            if (k == 3'd6) st <= S_UPD;
            else k <= k + 1'b1;
          end
        end
        // q = q*q + c, commit derivative
        S_UPD: begin
          q[0] <= sat64(nq[0] + 64'($signed(cfg.c_w)), QLIM);
          q[1] <= sat64(nq[1] + 64'($signed(cfg.c_x)), QLIM);
          q[2] <= sat64(nq[2] + 64'($signed(cfg.c_y)), QLIM);
          q[3] <= sat64(nq[3] + 64'($signed(cfg.c_z)), QLIM);
          for (int n = 0; n < 4; n++) dq[n] <= nd[n];
          m2 <= '0;
          i  <= '0;
          st <= S_M2;
        end
        // squared magnitude
        S_M2: begin
          if (mul_done) begin
            pend <= 1'b0;
            m2   <= m2 + mres;
            i    <= i + 1'b1;
            if (i == 2'd3) st <= S_CHK;
          end
        end
        // escape test
        S_CHK: begin
          if (!esc && (it != IT_W'(ESCAPE_ITERATIONS - 1))) begin
            it <= it + 1'b1;
            i  <= '0;
            j  <= '0;
            st <= S_ND;
          end else if (m2 == '0) begin
            d  <= '0;
            st <= S_DEC;
          end else begin
            sv <= m2;
            ss <= '0;
            st <= S_SQS;
          end
        end
        // scale radicand into range
        S_SQS: begin
          if ((sv >> (62 - FRAC_BITS)) != '0) begin
            sv <= sv >> 2;
            ss <= ss + 1'b1;
          end else begin
            st <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            pend <= 1'b0;
            sqv  <= $signed(64'(sq_root) << ss);
            lx   <= m2;
            ln_n <= 8'sd30;
            st   <= S_LNN;
          end
        end
        // log2 integer part by normalizing to q1.30
        S_LNN: begin
          if (lx >= 64'h8000_0000) begin
            lx   <= lx >> 1;
            ln_n <= ln_n + 8'sd1;
          end else if (lx < 64'h4000_0000) begin
            lx   <= lx << 1;
            ln_n <= ln_n - 8'sd1;
          end else begin
            lf <= '0;
            lc <= '0;
            st <= S_LNS;
          end
        end
        // log2 fraction by repeated squaring
        S_LNS: begin
          lx <= lxx[31] ? {33'd0, lxx[31:1]} : {32'd0, lxx};
          lf <= {lf[FRAC_BITS-2:0], lxx[31]};
          lc <= lc + 1'b1;
          if (lc == LNC_W'(FRAC_BITS - 1)) st <= S_LNM;
        end
        S_LNM: begin
          if (mul_done) begin
            pend <= 1'b0;
            lnv  <= mres;
            st   <= S_NUM;
          end
        end
        S_NUM: begin
          if (mul_done) begin
            pend <= 1'b0;
            num  <= mres;
            if (mres <= 64'sd0) begin
              d  <= mres;
              st <= S_DEC;
            end else begin
              st <= S_HMAX;
            end
          end
        end
        // derivative norm: block shift, then root of sum of squares
        S_HMAX: begin
          mx <= (m01 > m23) ? m01 : m23;
          hs <= '0;
          st <= S_HSH;
        end
        S_HSH: begin
          if ((mx >> hs) >= 64'h4000_0000) begin
            hs <= hs + 1'b1;
          end else begin
            i    <= '0;
            hsum <= '0;
            st   <= S_HSQ;
          end
        end
        S_HSQ: begin
          if (mul_done) begin
            pend <= 1'b0;
            hsum <= hsum + mres;
            i    <= i + 1'b1;
            if (i == 2'd3) st <= S_HROOT;
          end
        end
        S_HROOT: begin
          if (sq_done) begin
            pend <= 1'b0;
            if (dn == '0) begin
              d  <= DCAP;
              st <= S_DEC;
            end else begin
              den <= dn;
              rq  <= {num, 32'd0};
              rem <= '0;
              dc  <= '0;
              st  <= S_DIV;
            end
          end
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          rem <= ge ? (rs - {1'b0, den}) : rs;
          rq  <= {rq[DIV_W-2:0], ge};
          dc  <= dc + 1'b1;
          if (dc == DC_W'(DIV_W - 1)) st <= S_DFIN;
        end
        S_DFIN: begin
          d  <= (rq > DIV_W'(DCAP)) ? DCAP : $signed(rq[63:0]);
          st <= S_DEC;
        end
        // hit test and advance
        S_DEC: begin
          if (d <= $signed({33'd0, cfg.hit_distance})) begin
            hitr <= 1'b1;
            st   <= S_OUT;
          end else begin
            t  <= t + d;
            st <= S_ADV;
          end
        end
        S_ADV: begin
          if ((t >= MAX_DIST) || (step == STEP_W'(MARCH_STEPS - 1))) begin
            st <= S_OUT;
          end else begin
            step <= step + 1'b1;
            i    <= '0;
            st   <= S_POS;
          end
        end
        // result word into the output register
        S_OUT: begin
          if (!ov) begin
            o_hit <= hitr;
            o_x   <= p[0];
            o_y   <= p[1];
            o_z   <= p[2];
            ov    <= 1'b1;
            st    <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[src/quaternion_julia_ray_march_core.sv]
// Quaternion Julia ray marcher, distance-estimator sphere tracing.
// ray channel: one word per ray, a unit direction in signed q4.28.
// res channel: one word per ray: hit flag and the last marched point.
// cfg port: cfg_we writes cfg_data into register cfg_index (julia constant
// w/x/y/z, eye x/y/z, hit distance); write only while no ray is in flight.
// Each march step runs up to 10 quaternion iterations of 27 products on
// one shared 32x32 multiplier, then a square root, a 28-step log, six
// more products, a second root and a 96-bit divide, for each of the
// steps taken (at most 1024).
// Throughput: one ray at a time; a two-word queue accepts further rays
// while one is marched, and ray.ready drops when it is full.
// Reset (synchronous, rst high) empties the queue, idles the marcher,
// drops res.valid and loads the default constant, eye point and hit distance.
// A stalled receiver holds the result in the output register; the marcher
// waits in its final state until that register is free.
module quaternion_julia_ray_march_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [qjrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  qjrm_ray_if.sink                       ray,
  qjrm_res_if.source                     res
);
  import qjrm_pkg::*;

  cfg_t cfg;
  ray_t head;
  logic head_valid;
  logic pop;
  logic busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_w          <= RST_C_W;
      cfg.c_x          <= RST_C_X;
      cfg.c_y          <= RST_C_Y;
      cfg.c_z          <= RST_C_Z;
      cfg.eye_x        <= RST_EYE_X;
      cfg.eye_y        <= RST_EYE_Y;
      cfg.eye_z        <= RST_EYE_Z;
      cfg.hit_distance <= RST_HIT_D;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_C_W:          cfg.c_w          <= cfg_data;
        REG_C_X:          cfg.c_x          <= cfg_data;
        REG_C_Y:          cfg.c_y          <= cfg_data;
        REG_C_Z:          cfg.c_z          <= cfg_data;
        REG_EYE_X:        cfg.eye_x        <= cfg_data;
        REG_EYE_Y:        cfg.eye_y        <= cfg_data;
        REG_EYE_Z:        cfg.eye_z        <= cfg_data;
        REG_HIT_DISTANCE: cfg.hit_distance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // intake queue
  qjrm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ray        (ray),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // marcher and output register
  qjrm_march u_march (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .busy       (busy),
    .res        (res)
  );

`ifndef SYNTHESIS
  // the marcher only takes a ray that the queue holds
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("ray taken from empty queue");

  // a new result only follows marching work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(busy))
    else $error("result without a marched ray");

  // a taken ray sets the marcher busy
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> busy)
    else $error("marcher did not start on taken ray");
`endif

endmodule

[dv/tb_quaternion_julia_ray_march_core.sv]
module tb_quaternion_julia_ray_march_core;
  import qjrm_pkg::*;

  localparam longint ONE_Q     = 64'sd1 <<< FRAC_BITS;
  localparam longint Q_SAT     = (64'sd1 <<< (FRAC_BITS + 8)) - 64'sd1;
  localparam longint DQ_SAT    = (64'sd1 <<< 61) - 64'sd1;
  localparam longint I64_TOP   = 64'sh7fff_ffff_ffff_ffff;
  localparam longint STEP_CAP  = 64'sd16 <<< FRAC_BITS;
  localparam longint ESC_BOUND = 64'sd10 <<< FRAC_BITS;
  localparam longint FAR_BOUND = 64'sd10 <<< FRAC_BITS;
  localparam longint LN2_FRAC  = 64'sd2977044472;
  localparam longint CYCLE_CAP = 64'd1_200_000_000;
  // negated terms of a quaternion product, bit j of row i
  localparam bit [3:0] QUAT_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } ray_word_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } march_out_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  qjrm_ray_if ray_ch ();
  qjrm_res_if res_ch ();

  quaternion_julia_ray_march_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray(ray_ch), .res(res_ch)
  );

  // shadow of the configuration registers
  longint julia_c [4];
  longint eye_pt [3];
  longint hit_thr;

  ray_word_t  rays_pending[$];
  march_out_t march_expected[$];
  int         rays_planned;
  int         rays_taken_cnt;
  int         results_seen;
  int         hit_cnt;
  int         errors;
  bit         calm;
  bit         ray_taken;
  int         hold_requests;
  int         hold_served;
  int         hold_left;
  longint     cycle_cnt;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // arithmetic of the marcher
  function automatic longint unsigned magn(longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic longint unsigned mul_shr(longint unsigned a, longint unsigned b,
                                              int s, longint unsigned lim);
    logic [127:0] p;
    logic [127:0] r;
    p = {64'd0, a} * {64'd0, b};
    r = p >> s;
    if (r[127:64] != 0) return lim;
    return (r[63:0] > lim) ? lim : r[63:0];
  endfunction

  function automatic longint smul_sat(longint a, longint b, int s, longint lim);
    longint unsigned m;
    m = mul_shr(magn(a), magn(b), s, lim);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned norm_q(longint unsigned v);
    int s;
    s = 0;
    while ((v >> (62 - FRAC_BITS)) != 0) begin
      v = v >> 2;
      s++;
    end
    return root64(v << FRAC_BITS) << s;
  endfunction

  function automatic longint unsigned norm_dq(longint d [4]);
    longint unsigned m [4];
    longint unsigned mx, sum;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = magn(d[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 4; i++) sum += (m[i] >> s) * (m[i] >> s);
    return root64(sum) << s;
  endfunction

  // natural log via leading one plus squaring steps
  function automatic longint log_nat(longint unsigned v);
    int n;
    longint unsigned x, f;
    n = 63;
    f = 0;
    while (n > 0 && !v[n]) n--;
    x = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
    for (int i = 0; i < FRAC_BITS; i++) begin
      x = (x * x) >> 30;
      f = f << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        f = f | 64'd1;
      end
    end
    return smul_sat(longint'(n - FRAC_BITS) * ONE_Q + longint'(f), LN2_FRAC, 32, I64_TOP);
  endfunction

  function automatic longint dist_est(longint p [3]);
    longint q [4], dq [4], nq [4], nd [4], num, acc, tm;
    longint unsigned m2, den, qi, r, qo;
    q[0] = p[0]; q[1] = p[1]; q[2] = p[2]; q[3] = 0;
    dq[0] = 64'sd1 <<< 32; dq[1] = 0; dq[2] = 0; dq[3] = 0;
    m2 = 0;
    for (int it = 0; it < ESCAPE_ITERATIONS; it++) begin
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) begin
          tm = smul_sat(q[j], dq[i ^ j], FRAC_BITS - 1, DQ_SAT);
          acc = QUAT_NEG[i][j] ? acc - tm : acc + tm;
        end
        nd[i] = clip(acc, DQ_SAT);
      end
      nq[0] = smul_sat(q[0], q[0], FRAC_BITS, Q_SAT);
      for (int j = 1; j < 4; j++) nq[0] -= smul_sat(q[j], q[j], FRAC_BITS, Q_SAT);
      for (int i = 1; i < 4; i++) nq[i] = smul_sat(q[i], q[0], FRAC_BITS - 1, Q_SAT);
      m2 = 0;
      for (int i = 0; i < 4; i++) begin
        q[i] = clip(nq[i] + julia_c[i], Q_SAT);
        dq[i] = nd[i];
        m2 += longint'(smul_sat(q[i], q[i], FRAC_BITS, I64_TOP));
      end
      if (m2 > ESC_BOUND) break;
    end
    // zero magnitude counts as on the surface
    if (m2 == 0) return 0;
    num = smul_sat(longint'(norm_q(m2)), log_nat(m2), FRAC_BITS + 2, I64_TOP);
    if (num <= 0) return num;
    den = norm_dq(dq);
    if (den == 0) return STEP_CAP;
    qi = longint'(num) / den;
    if (qi > (STEP_CAP >> 32)) return STEP_CAP;
    r = longint'(num) % den;
    qo = qi;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      qo = qo << 1;
      if (r >= den) begin
        r = r - den;
        qo = qo | 64'd1;
      end
    end
    return (qo > STEP_CAP) ? STEP_CAP : longint'(qo);
  endfunction

  function automatic march_out_t march_ray(ray_word_t w);
    longint dir [3], p [3], t, d, v;
    march_out_t o;
    dir[0] = w.dx; dir[1] = w.dy; dir[2] = w.dz;
    p[0] = 0; p[1] = 0; p[2] = 0;
    t = ONE_Q;
    o.hit = 1'b0;
    for (int step = 0; step < MARCH_STEPS; step++) begin
      for (int i = 0; i < 3; i++) begin
        v = eye_pt[i] + smul_sat(dir[i], t, FRAC_BITS, I64_TOP / 4);
        p[i] = v > 64'sh7fff_ffff ? 64'sh7fff_ffff :
               (v < -64'sh8000_0000 ? -64'sh8000_0000 : v);
      end
      d = dist_est(p);
      if (d <= hit_thr) begin
        o.hit = 1'b1;
        break;
      end
      t += d;
      if (t >= FAR_BOUND) break;
    end
    o.px = p[0][31:0];
    o.py = p[1][31:0];
    o.pz = p[2][31:0];
    return o;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ray driver
  always @(negedge clk) begin
    ray_word_t w;
    if (!rst && (!ray_ch.valid || ray_taken)) begin
      if (rays_pending.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
        w = rays_pending.pop_front();
        ray_ch.dir_x <= w.dx;
        ray_ch.dir_y <= w.dy;
        ray_ch.dir_z <= w.dz;
        ray_ch.valid <= 1'b1;
      end else begin
        ray_ch.valid <= 1'b0;
      end
    end
  end

  // accepted rays get their expected word
  always @(posedge clk) begin
    ray_word_t w;
    ray_taken <= ray_ch.valid && ray_ch.ready;
    if (!rst && ray_ch.valid && ray_ch.ready) begin
      w.dx = ray_ch.dir_x;
      w.dy = ray_ch.dir_y;
      w.dz = ray_ch.dir_z;
      march_expected.push_back(march_ray(w));
      rays_taken_cnt <= rays_taken_cnt + 1;
    end
  end

  // result receiver with random stalls and requested long hold-offs
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_served < hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left <= 30000;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    march_out_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      if (march_expected.size() == 0) begin
        $error("result word with no ray outstanding");
        errors++;
      end else begin
        e = march_expected.pop_front();
        if (res_ch.hit) hit_cnt++;
        if (res_ch.hit !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, res_ch.hit);
          errors++;
        end
        if (res_ch.pos_x !== e.px) begin
          $error("pos_x: expected %0d actual %0d", e.px, res_ch.pos_x);
          errors++;
        end
        if (res_ch.pos_y !== e.py) begin
          $error("pos_y: expected %0d actual %0d", e.py, res_ch.pos_y);
          errors++;
        end
        if (res_ch.pos_z !== e.pz) begin
          $error("pos_z: expected %0d actual %0d", e.pz, res_ch.pos_z);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_C_W:          julia_c[0] = longint'(signed'(val));
      REG_C_X:          julia_c[1] = longint'(signed'(val));
      REG_C_Y:          julia_c[2] = longint'(signed'(val));
      REG_C_Z:          julia_c[3] = longint'(signed'(val));
      REG_EYE_X:        eye_pt[0] = longint'(signed'(val));
      REG_EYE_Y:        eye_pt[1] = longint'(signed'(val));
      REG_EYE_Z:        eye_pt[2] = longint'(signed'(val));
      REG_HIT_DISTANCE: hit_thr = longint'({33'd0, val[30:0]});
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_ray(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    ray_word_t w;
    w.dx = x;
    w.dy = y;
    w.dz = z;
    rays_pending.push_back(w);
    rays_planned++;
  endtask

  // random unit direction, or raw random words now and then
  task automatic add_random_rays(int n);
    real a, b, c, len;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 35) begin
        add_ray($urandom, $urandom, $urandom);
      end else begin
        a = real'($urandom_range(2000)) - 1000.0;
        b = real'($urandom_range(2000)) - 1000.0;
        c = real'($urandom_range(2000)) - 1000.0;
        len = $sqrt(a * a + b * b + c * c) + 1.0e-9;
        add_ray($rtoi(a / len * 268435456.0), $rtoi(b / len * 268435456.0),
                $rtoi(c / len * 268435456.0));
      end
    end
  endtask

  task automatic wait_done();
    @(negedge clk);
    while (rays_taken_cnt != rays_planned || results_seen != rays_planned) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_q(int lo_milli, int hi_milli);
    return $rtoi(real'(int'($urandom_range(hi_milli - lo_milli)) + lo_milli) / 1000.0 *
                 268435456.0);
  endfunction

  // stimulus phases
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ray_ch.valid = 1'b0;
    ray_ch.dir_x = '0;
    ray_ch.dir_y = '0;
    ray_ch.dir_z = '0;
    res_ch.ready = 1'b0;
    errors = 0;
    hit_cnt = 0;
    rays_planned = 0;
    rays_taken_cnt = 0;
    results_seen = 0;
    calm = 1'b0;
    ray_taken = 1'b0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    cycle_cnt = 0;
    julia_c[0] = RST_C_W; julia_c[1] = RST_C_X;
    julia_c[2] = RST_C_Y; julia_c[3] = RST_C_Z;
    eye_pt[0] = RST_EYE_X; eye_pt[1] = RST_EYE_Y; eye_pt[2] = RST_EYE_Z;
    hit_thr = RST_HIT_D;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset constants: axis rays, extremes, zero direction
    add_ray(32'h0, 32'h0, 32'hf000_0000);
    add_ray(32'h1000_0000, 32'h0, 32'h0);
    add_ray(32'h0, 32'h1000_0000, 32'h0);
    add_ray(32'h0, 32'h0, 32'h1000_0000);
    add_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_ray(32'h0, 32'h0, 32'h0);
    add_ray(32'hffff_ffff, 32'h0000_0001, 32'hf000_0000);
    add_ray(32'h0b50_4f33, 32'h0, 32'hf4af_b0cd);
    add_random_rays(22);
    wait_done();

    // random moderate constants and eye, no idling
    calm = 1'b1;
    write_reg(REG_C_W, rnd_q(-800, 800));
    write_reg(REG_C_X, rnd_q(-800, 800));
    write_reg(REG_C_Y, rnd_q(-800, 800));
    write_reg(REG_C_Z, rnd_q(-800, 800));
    write_reg(REG_EYE_X, rnd_q(-1000, 1000));
    write_reg(REG_EYE_Y, rnd_q(-1000, 1000));
    write_reg(REG_EYE_Z, rnd_q(1500, 3000));
    write_reg(REG_HIT_DISTANCE, $urandom_range(2000000, 100000));
    end_writes();
    add_random_rays(18);
    wait_done();
    calm = 1'b0;

    // largest hit distance, largest w and x constants, long receiver hold-off
    write_reg(REG_C_W, 32'h7fff_ffff);
    write_reg(REG_C_X, 32'h7fff_ffff);
    write_reg(REG_HIT_DISTANCE, 32'h7fff_ffff);
    end_writes();
    hold_requests++;
    add_random_rays(10);
    wait_done();

    // zero hit distance, extreme constants, far eye
    write_reg(REG_C_W, 32'h8000_0000);
    write_reg(REG_C_Y, 32'h8000_0000);
    write_reg(REG_C_Z, 32'h7fff_ffff);
    write_reg(REG_EYE_X, 32'h7fff_ffff);
    write_reg(REG_EYE_Y, 32'h8000_0000);
    write_reg(REG_EYE_Z, 32'h8000_0000);
    write_reg(REG_HIT_DISTANCE, 32'h0);
    end_writes();
    add_ray(32'h0, 32'h0, 32'h0);
    add_ray(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_random_rays(10);
    wait_done();

    // all-zero constant and eye: zero magnitude point
    for (int r = 0; r < 7; r++) write_reg(cfg_reg_t'(r), 32'h0);
    write_reg(REG_HIT_DISTANCE, 32'h0000_0100);
    end_writes();
    add_ray(32'h0, 32'h0, 32'h0);
    add_ray(32'h0, 32'h0, 32'h1000_0000);
    add_random_rays(6);
    wait_done();

    // back to the default scene
    write_reg(REG_C_W, RST_C_W);
    write_reg(REG_C_X, RST_C_X);
    write_reg(REG_C_Y, RST_C_Y);
    write_reg(REG_C_Z, RST_C_Z);
    write_reg(REG_EYE_X, RST_EYE_X);
    write_reg(REG_EYE_Y, RST_EYE_Y);
    write_reg(REG_EYE_Z, RST_EYE_Z);
    write_reg(REG_HIT_DISTANCE, RST_HIT_D);
    end_writes();
    add_random_rays(15);
    wait_done();

    $display("marched %0d rays over six register settings: %0d hits, %0d misses",
             results_seen, hit_cnt, results_seen - hit_cnt);
    if (errors == 0 && march_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
